@@ sv/tsc_pkg.sv @@
package tsc_pkg;

    localparam int WORD_BITS      = 16;
    localparam int THRESH_BITS    = 12;
    localparam int COUNT_BITS     = 8;
    localparam int NUM_AXES       = 3;
    localparam int AXIS_W         = 2;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 12;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic signed [THRESH_BITS-1:0] THRESH_RESET = 12'sd1300;
    localparam logic [COUNT_BITS-1:0]         MIN_RESET    = 8'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_THRESHOLD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_STEPS      = 1'b1;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // per-lane crossing flags: both samples above, both samples below
    typedef struct packed {
        logic hi;
        logic lo;
    } t_lane_flags;

endpackage

@@ sv/accel_threshold_step_counter.sv @@
// channel   | direction | handshake                     | payload
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: word_x/y/z; tlast: frame_end
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: step_count
// cfg       | in        | i_cfg_we (no wait)            | i_cfg_addr, i_cfg_wdata
//
// One sample triple per cycle while s_axis_tready is high; the three axis lanes
// compare in parallel and the merge stage updates arm state and count in the same cycle.
// A frame's count appears on m_axis in the cycle after its last triple is taken.
// A held result blocks input: s_axis_tready drops while a result waits and
// m_axis_tready is low, and rises again in the cycle the result is taken.
// Synchronous active-low reset; config registers return to 1300 and 3.
module accel_threshold_step_counter import tsc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [3*WORD_BITS-1:0]  s_axis_tdata,   // word_x, word_y, word_z
    input  logic                    s_axis_tlast,   // frame_end
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [COUNT_BITS-1:0]   m_axis_tdata,   // step_count
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic signed [THRESH_BITS-1:0] r_thresh;
    logic [COUNT_BITS-1:0]         r_min_steps;
    t_lane_flags [NUM_AXES-1:0]    w_flags;
    logic                          w_accept;
    logic                          w_in_ready;

    assign s_axis_tready = w_in_ready;
    assign w_accept      = s_axis_tvalid && w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RESET;
            r_min_steps <= MIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_STEP_THRESHOLD: r_thresh    <= $signed(i_cfg_wdata[THRESH_BITS-1:0]);
                CFG_MIN_STEPS:      r_min_steps <= i_cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        tsc_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_word    (s_axis_tdata[g*WORD_BITS +: WORD_BITS]),
            .i_thresh  (r_thresh),
            .i_advance (w_accept),
            .i_clear   (s_axis_tlast),
            .o_flags   (w_flags[g])
        );
    end

    tsc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flags     (w_flags),
        .i_accept    (w_accept),
        .i_frame_end (s_axis_tlast),
        .i_min_steps (r_min_steps),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

@@ sv/tsc_lane.sv @@
module tsc_lane import tsc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [WORD_BITS-1:0]          i_word,
    input  logic signed [THRESH_BITS-1:0] i_thresh,
    input  logic                          i_advance,
    input  logic                          i_clear,
    output t_lane_flags                   o_flags
);

    localparam int CMP_W = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    logic signed [SAMPLE_BITS-1:0] w_cur;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic signed [SAMPLE_BITS-1:0] n_prev;
    logic signed [CMP_W-1:0]       w_cur_x;
    logic signed [CMP_W-1:0]       w_prev_x;
    logic signed [CMP_W-1:0]       w_th_x;

    assign w_cur    = $signed(i_word[SAMPLE_BITS-1:0]);
    assign w_cur_x  = CMP_W'(w_cur);
    assign w_prev_x = CMP_W'(r_prev);
    assign w_th_x   = CMP_W'(i_thresh);

    assign o_flags.hi = (w_cur_x > w_th_x) && (w_prev_x > w_th_x);
    assign o_flags.lo = (w_cur_x < w_th_x) && (w_prev_x < w_th_x);

    always_comb begin
        n_prev = r_prev;
        if (i_advance) begin
            n_prev = i_clear ? '0 : w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else begin
            r_prev <= n_prev;
        end
    end

endmodule

@@ sv/tsc_merge.sv @@
module tsc_merge import tsc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_flags [NUM_AXES-1:0]    i_flags,
    input  logic                          i_accept,
    input  logic                          i_frame_end,
    input  logic [COUNT_BITS-1:0]         i_min_steps,
    input  logic                          i_out_ready,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    output logic [COUNT_BITS-1:0]         o_out_data
);

    logic                  r_have_prev, n_have_prev;
    logic                  r_armed, n_armed;
    t_axis                 r_axis, n_axis;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic [COUNT_BITS-1:0] r_out_data, n_out_data;
    logic                  w_fall;

    // free slot when empty or the held result leaves this cycle
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        case (r_axis)
            AXIS_X:  w_fall = i_flags[0].lo;
            AXIS_Y:  w_fall = i_flags[1].lo;
            AXIS_Z:  w_fall = i_flags[2].lo;
            default: w_fall = 1'b0;
        endcase
    end

    always_comb begin
        n_have_prev = r_have_prev;
        n_armed     = r_armed;
        n_axis      = r_axis;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        if (i_accept) begin
            if (r_have_prev) begin
                if (r_armed) begin
                    if (w_fall) begin
                        n_armed = 1'b0;
                        if (r_count != '1) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end else if (i_flags[0].hi) begin
                    n_armed = 1'b1;
                    n_axis  = AXIS_X;
                end else if (i_flags[1].hi) begin
                    n_armed = 1'b1;
                    n_axis  = AXIS_Y;
                end else if (i_flags[2].hi) begin
                    n_armed = 1'b1;
                    n_axis  = AXIS_Z;
                end
            end
            n_have_prev = 1'b1;
            if (i_frame_end) begin
                n_out_valid = 1'b1;
                n_out_data  = (n_count < i_min_steps) ? '0 : n_count;
                n_have_prev = 1'b0;
                n_armed     = 1'b0;
                n_axis      = AXIS_X;
                n_count     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_armed     <= 1'b0;
            r_axis      <= AXIS_X;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_have_prev <= n_have_prev;
            r_armed     <= n_armed;
            r_axis      <= n_axis;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_frame_end) |=> (r_out_valid && !r_armed && !r_have_prev && r_count == '0))
        else $error("frame end did not post a result and clear state");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_frame_end) |=> (r_count >= $past(r_count)))
        else $error("step count went down inside a frame");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> ($stable(r_armed) && $stable(r_count) && $stable(r_have_prev)))
        else $error("state changed without an input transfer");

    a_step_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_frame_end && !r_armed) |=> (r_count == $past(r_count)))
        else $error("step counted while not armed");

endmodule

@@ dv/tb.sv @@
module tb import tsc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
    localparam int HOLD_CYCLES = 300;

    // Tracks thresholds, arm state and per-frame step totals; holds the counts still owed.
    class step_count_tracker;
        int   thr;
        int   min_steps;
        int   prev [NUM_AXES];
        bit   have_prev;
        bit   armed;
        t_axis axis;
        int   steps;
        int   counts_due [$];
        int   errors;
        int   checked;
        int   largest;

        function new();
            thr       = int'(THRESH_RESET);
            min_steps = int'(MIN_RESET);
            errors    = 0;
            checked   = 0;
            largest   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (prev[i]) prev[i] = 0;
            have_prev = 1'b0;
            armed     = 1'b0;
            axis      = AXIS_X;
            steps     = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr == CFG_STEP_THRESHOLD) begin
                thr = int'($signed(data[THRESH_BITS-1:0]));
            end else if (addr == CFG_MIN_STEPS) begin
                min_steps = int'(data[COUNT_BITS-1:0]);
            end
        endfunction

        function void take_sample(logic [3*WORD_BITS-1:0] d, logic last);
            int cur [NUM_AXES];
            logic signed [SAMPLE_BITS_DEF-1:0] s;
            for (int a = 0; a < NUM_AXES; a++) begin
                s = d[a*WORD_BITS +: SAMPLE_BITS_DEF];
                cur[a] = int'(s);
            end
            // first sample of a frame has no predecessor: skip both crossing tests
            if (have_prev) begin
                if (armed) begin
                    if (cur[axis] < thr && prev[axis] < thr) begin
                        armed = 1'b0;
                        if (steps < COUNT_MAX) steps++;
                    end
                end else begin
                    for (int a = 0; a < NUM_AXES && !armed; a++) begin
                        if (cur[a] > thr && prev[a] > thr) begin
                            armed = 1'b1;
                            axis  = t_axis'(a);
                        end
                    end
                end
            end
            prev      = cur;
            have_prev = 1'b1;
            if (last) begin
                counts_due.push_back(steps < min_steps ? 0 : steps);
                clear_frame();
            end
        endfunction

        function void report(string what, int want, int got);
            errors++;
            if (errors <= 10) $display("%s: expected %0d, got %0d", what, want, got);
        endfunction

        function void check_count(logic [COUNT_BITS-1:0] got);
            int want;
            checked++;
            if (int'(got) > largest) largest = int'(got);
            if (counts_due.size() == 0) begin
                report("step_count with no frame pending", -1, int'(got));
                return;
            end
            want = counts_due.pop_front();
            if (got !== want[COUNT_BITS-1:0]) report("step_count mismatch", want, int'(got));
        endfunction

        function void close();
            if (counts_due.size() != 0) begin
                report("frames never reported", 0, counts_due.size());
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [3*WORD_BITS-1:0]  s_axis_tdata;   // word_x, word_y, word_z
    logic                    s_axis_tlast;   // frame_end
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [COUNT_BITS-1:0]   m_axis_tdata;   // step_count
    logic                    i_cfg_we;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata;

    step_count_tracker tracker = new();

    bit quiet;
    bit hold_req;
    int hold_left;
    int cur_thr;
    bit above [NUM_AXES];
    int n_items;
    int n_settings;

    always #6 i_clk = ~i_clk;

    accel_threshold_step_counter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) tracker.check_count(m_axis_tdata);
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic send_triple(input logic [3*WORD_BITS-1:0] d, input logic last);
        while (!quiet && $urandom_range(0, 99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_sample(d, last);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic send_samples(input int x, input int y, input int z, input logic last);
        send_triple({4'h0, z[11:0], 4'h0, y[11:0], 4'h0, x[11:0]}, last);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.write_reg(addr, data);
        @(negedge i_clk);
    endtask

    // drop valid, wait out every owed count, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.counts_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // sample near the threshold, staying on one side for a few items at a time
    function automatic logic [WORD_BITS-1:0] axis_word(int a);
        int v;
        if ($urandom_range(0, 99) < 30) above[a] = !above[a];
        if ($urandom_range(0, 99) < 6) v = cur_thr;
        else if (above[a]) v = cur_thr + $urandom_range(1, 400);
        else v = cur_thr - $urandom_range(1, 400);
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return {4'($urandom), v[11:0]};
    endfunction

    task automatic run_frame(input int len);
        logic [3*WORD_BITS-1:0] d;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 10) begin
                d = {16'($urandom), 16'($urandom), 16'($urandom)};
            end else begin
                d = {axis_word(2), axis_word(1), axis_word(0)};
            end
            send_triple(d, i == len - 1);
        end
    endtask

    task automatic run_phase(input int thr, input int min_val, input int n);
        int done_items;
        int len;
        write_cfg(CFG_STEP_THRESHOLD, thr[11:0]);
        write_cfg(CFG_MIN_STEPS, {4'($urandom), min_val[7:0]});
        cur_thr = thr;
        n_settings++;
        done_items = 0;
        while (done_items < n) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            run_frame(len);
            done_items += len;
        end
        drain();
    endtask

    int thr_list [6] = '{-2048, 2047, 0, -700, 1300, 555};
    int min_list [6] = '{0, 255, 1, 2, 3, 0};

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        cur_thr       = 1300;
        n_items       = 0;
        n_settings    = 1;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset register values; lone first sample with word extremes
        send_triple({16'h07FF, 16'hFFFF, 16'h0000}, 1'b1);
        // upper word bits set, most negative x and y samples
        send_triple({16'h5FFF, 16'hA800, 16'hF800}, 1'b0);
        send_samples(1400, 1400, 1400, 1'b0);
        // all axes above: x wins
        send_samples(1400, 1400, 1400, 1'b0);
        send_samples(1400, 0, 0, 1'b0);
        send_samples(0, 0, 0, 1'b0);
        send_samples(0, 0, 0, 1'b0);
        // x sitting exactly on the threshold does not count as above
        send_samples(1300, 1301, 0, 1'b0);
        send_samples(1300, 1301, 0, 1'b0);
        send_samples(2047, 1299, 0, 1'b0);
        send_samples(2047, 1299, 0, 1'b0);
        send_samples(0, 0, 2047, 1'b0);
        send_samples(0, 0, 2047, 1'b0);
        send_samples(0, 0, -2048, 1'b0);
        send_samples(2047, 0, -2048, 1'b1);
        // new frame: history cleared, so the first high x cannot arm
        send_samples(2047, 0, 0, 1'b0);
        send_samples(2047, 0, 0, 1'b0);
        send_samples(-5, 0, 0, 1'b0);
        send_samples(-5, 0, 0, 1'b0);
        send_samples(1500, 0, 0, 1'b0);
        send_samples(1500, 0, 0, 1'b0);
        send_samples(-5, 0, 0, 1'b0);
        send_samples(-5, 0, 0, 1'b1);
        drain();

        for (int p = 0; p < 6; p++) begin
            if (p == 1) hold_req = 1'b1;
            quiet = (p == 3);
            run_phase(thr_list[p], min_list[p], 80);
        end
        quiet = 1'b0;

        tracker.close();
        $display("covered %0d input triples, %0d counts checked, largest count %0d",
                 n_items, tracker.checked, tracker.largest);
        $display("went through %0d register settings incl. both threshold extremes",
                 n_settings);
        if (tracker.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d failures", tracker.errors);
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

@@ accel_threshold_step_counter.f @@
sv/tsc_pkg.sv
sv/tsc_lane.sv
sv/tsc_merge.sv
sv/accel_threshold_step_counter.sv
dv/tb.sv
